// File: hdl/ptfl_pkg.sv
// Shared types and constants for the page translation block.
package ptfl_pkg;

  localparam int DEF_MAX_PAGES  = 64;
  localparam int DEF_PAGE_BYTES = 1024;

  localparam int VA_W        = 20;
  localparam int AGE_W       = 32;
  localparam int EVICT_W     = 6;
  localparam int PCOUNT_W    = 7;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;

  localparam int FRAME_STRIDE    = 10;
  localparam int RESET_RESIDENT  = 3;
  localparam int DEF_PAGE_COUNT  = 64;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPLACEMENT_MODE = 1'b0,
    CFG_PAGE_COUNT       = 1'b1
  } ptfl_cfg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_DONE
  } ptfl_state_e;

  typedef struct packed {
    logic             resident;
    logic [AGE_W-1:0] age;
  } ptfl_entry_t;

  typedef struct packed {
    logic               done;
    logic               fault;
    logic [EVICT_W-1:0] evicted;
  } ptfl_status_t;

  typedef struct packed {
    logic [EVICT_W-1:0] evicted_page;
    logic               page_fault;
    logic               out_of_range;
    logic [VA_W-1:0]    physical_address;
  } ptfl_result_t;

endpackage

// File: hdl/ptfl_age_alu.sv
// Shared age unit: saturating increment of one entry and compare against the running maximum.
module ptfl_age_alu (
  input  ptfl_pkg::ptfl_entry_t             entry_i,
  input  logic [ptfl_pkg::AGE_W-1:0]        best_age_i,
  output ptfl_pkg::ptfl_entry_t             entry_o,
  output logic                              better_o
);
  import ptfl_pkg::*;

  always_comb begin
    entry_o.resident = entry_i.resident;
    if (entry_i.resident && (entry_i.age != AGE_MAX)) begin
      entry_o.age = entry_i.age + AGE_W'(1);
    end else begin
      entry_o.age = entry_i.age;
    end
    // Strictly greater, so the lowest index wins a tie and age zero never wins.
    better_o = entry_o.resident && (entry_o.age > best_age_i);
  end

endmodule

// File: hdl/ptfl_page_mem.sv
// Page table memory: one write port and one registered read port.
module ptfl_page_mem #(
  parameter int MAX_PAGES = ptfl_pkg::DEF_MAX_PAGES,
  localparam int IDX_W = $clog2(MAX_PAGES)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IDX_W-1:0]      waddr_i,
  input  ptfl_pkg::ptfl_entry_t wdata_i,
  input  logic [IDX_W-1:0]      raddr_i,
  output ptfl_pkg::ptfl_entry_t rdata_o
);
  import ptfl_pkg::*;

  ptfl_entry_t mem_q [MAX_PAGES];
  ptfl_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/ptfl_seq.sv
// Sequencer: clearing pass, ageing scan with victim search, and replacement writes.
module ptfl_seq #(
  parameter int MAX_PAGES = ptfl_pkg::DEF_MAX_PAGES,
  localparam int IDX_W = $clog2(MAX_PAGES),
  localparam int CNT_W = $clog2(MAX_PAGES + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   oor_i,
  input  logic [IDX_W-1:0]       page_i,
  input  logic                   mode_i,
  input  logic [CNT_W-1:0]       limit_i,
  input  logic                   out_free_i,
  output logic                   ready_o,
  output ptfl_pkg::ptfl_status_t status_o,
  output logic                   mem_we_o,
  output logic [IDX_W-1:0]       mem_waddr_o,
  output ptfl_pkg::ptfl_entry_t  mem_wdata_o,
  output logic [IDX_W-1:0]       mem_raddr_o,
  input  ptfl_pkg::ptfl_entry_t  mem_rdata_i
);
  import ptfl_pkg::*;

  ptfl_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              rv_q, rv_d;
  logic [IDX_W-1:0]  pi_q, pi_d;
  logic [AGE_W-1:0]  best_age_q, best_age_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic              pres_q, pres_d;
  logic [AGE_W-1:0]  page_age_q, page_age_d;
  logic              fault_q, fault_d;

  ptfl_entry_t alu_entry;
  logic        alu_better;
  logic        clr_res;

  ptfl_age_alu u_alu (
    .entry_i    (mem_rdata_i),
    .best_age_i (best_age_q),
    .entry_o    (alu_entry),
    .better_o   (alu_better)
  );

  assign clr_res = (32'(cnt_q) < 32'(RESET_RESIDENT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
      fault_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
      fault_q <= fault_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pi_q       <= pi_d;
    best_age_q <= best_age_d;
    best_idx_q <= best_idx_d;
    pres_q     <= pres_d;
    page_age_q <= page_age_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rv_d        = rv_q;
    pi_d        = pi_q;
    best_age_d  = best_age_q;
    best_idx_d  = best_idx_q;
    pres_d      = pres_q;
    page_age_d  = page_age_q;
    fault_d     = fault_q;
    ready_o     = 1'b0;
    status_o    = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = pi_q;
    mem_wdata_o = alu_entry;
    mem_raddr_o = '0;

    case (state_q)
      ST_CLEAR: begin
        mem_we_o             = 1'b1;
        mem_waddr_o          = cnt_q[IDX_W-1:0];
        mem_wdata_o.resident = clr_res;
        mem_wdata_o.age      = clr_res ? AGE_W'(cnt_q) : '0;
        cnt_d                = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(MAX_PAGES - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ready_o = 1'b1;
        if (start_i) begin
          cnt_d      = '0;
          rv_d       = 1'b0;
          best_age_d = '0;
          best_idx_d = '0;
          pres_d     = 1'b0;
          page_age_d = '0;
          fault_d    = 1'b0;
          state_d    = oor_i ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Reads run one entry ahead of the write-back of the aged entry.
        if (cnt_q < limit_i) begin
          mem_raddr_o = cnt_q[IDX_W-1:0];
          pi_d        = cnt_q[IDX_W-1:0];
          rv_d        = 1'b1;
          cnt_d       = cnt_q + CNT_W'(1);
        end else begin
          rv_d = 1'b0;
        end
        if (rv_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pi_q;
          mem_wdata_o = alu_entry;
          if (alu_better) begin
            best_age_d = alu_entry.age;
            best_idx_d = pi_q;
          end
          if (pi_q == page_i) begin
            pres_d     = mem_rdata_i.resident;
            page_age_d = alu_entry.age;
          end
        end else if (cnt_q >= limit_i) begin
          if (pres_q) begin
            if (mode_i == MODE_LRU) begin
              mem_we_o             = 1'b1;
              mem_waddr_o          = page_i;
              mem_wdata_o.resident = 1'b1;
              mem_wdata_o.age      = '0;
            end
            state_d = ST_DONE;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = best_idx_q;
            mem_wdata_o = '0;
            fault_d     = 1'b1;
            state_d     = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        // The victim may be the requested page itself when nothing else qualified.
        mem_we_o             = 1'b1;
        mem_waddr_o          = page_i;
        mem_wdata_o.resident = 1'b1;
        mem_wdata_o.age      = (best_idx_q == page_i) ? '0 : page_age_q;
        state_d              = ST_DONE;
      end
      ST_DONE: begin
        status_o.done    = out_free_i;
        status_o.fault   = fault_q;
        status_o.evicted = fault_q ? EVICT_W'(best_idx_q) : '0;
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/page_translate_fifo_lru.sv
// Top level of the demand-paging address translator with FIFO or LRU replacement.
//
// Each virtual address is split into a page number and an in-page offset and is translated
// to frame (page times ten) concatenated with the offset. Each in-range item runs a scan
// over the page table memory, which ages every entry in the active range and tracks the
// oldest resident page through one shared age unit, one entry per cycle; an out-of-range
// item skips the scan. After reset the block loads the table's initial contents before
// it accepts its first transfer; configuration writes are taken at any time. The result
// register lets a new transfer in while the previous result waits on the output.
module page_translate_fifo_lru #(
  parameter int MAX_PAGES  = ptfl_pkg::DEF_MAX_PAGES,
  parameter int PAGE_BYTES = ptfl_pkg::DEF_PAGE_BYTES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [19:0] virtual_address, [23:20] zero
  input  logic [ptfl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [19:0] physical_address, [25:20] evicted_page, [31:26] zero
  output logic [ptfl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [0] out_of_range, [1] page_fault
  output logic [ptfl_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  input  logic                              cfg_we_i,
  input  logic [ptfl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ptfl_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ptfl_pkg::*;

  localparam int IDX_W = $clog2(MAX_PAGES);
  localparam int CNT_W = $clog2(MAX_PAGES + 1);
  localparam int OFF_W = $clog2(PAGE_BYTES);
  localparam int PN_W  = VA_W - OFF_W;

  logic                mode_q;
  logic [PCOUNT_W-1:0] page_count_q;
  logic [IDX_W-1:0]    page_q;
  logic                oor_q;
  logic [VA_W-1:0]     phys_q;
  logic                out_valid_q, out_valid_d;
  ptfl_result_t        out_q, out_d;

  logic [PN_W-1:0]     pn;
  logic [31:0]         pn32;
  logic [31:0]         lim32;
  logic [31:0]         frame32;
  logic                oor;
  logic [VA_W-1:0]     phys;
  logic                in_xfer;
  logic                out_free;
  logic                seq_ready;
  ptfl_status_t        status;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  ptfl_entry_t         mem_wdata;
  logic [IDX_W-1:0]    mem_raddr;
  ptfl_entry_t         mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_FIFO;
      page_count_q <= PCOUNT_W'(DEF_PAGE_COUNT);
    end else if (cfg_we_i) begin
      case (ptfl_cfg_e'(cfg_idx_i))
        CFG_REPLACEMENT_MODE: mode_q       <= cfg_data_i[0];
        CFG_PAGE_COUNT:       page_count_q <= cfg_data_i[PCOUNT_W-1:0];
        default:              mode_q       <= mode_q;
      endcase
    end
  end

  // Page number, clamped page count and frame address.
  always_comb begin
    pn      = s_axis_tdata[VA_W-1:OFF_W];
    pn32    = 32'(pn);
    lim32   = (32'(page_count_q) > 32'(MAX_PAGES)) ? 32'(MAX_PAGES) : 32'(page_count_q);
    oor     = (pn32 >= lim32);
    frame32 = (pn32 << 3) + (pn32 << 1);
    phys    = {frame32[PN_W-1:0], s_axis_tdata[OFF_W-1:0]};
  end

  assign in_xfer       = s_axis_tvalid && seq_ready;
  assign s_axis_tready = seq_ready;
  assign out_free      = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      page_q <= pn32[IDX_W-1:0];
      oor_q  <= oor;
      phys_q <= oor ? '0 : phys;
    end
  end

  ptfl_seq #(
    .MAX_PAGES (MAX_PAGES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_xfer),
    .oor_i       (oor),
    .page_i      (page_q),
    .mode_i      (mode_q),
    .limit_i     (lim32[CNT_W-1:0]),
    .out_free_i  (out_free),
    .ready_o     (seq_ready),
    .status_o    (status),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ptfl_page_mem #(
    .MAX_PAGES (MAX_PAGES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    out_d                  = out_q;
    out_valid_d            = out_valid_q && !m_axis_tready;
    if (status.done) begin
      out_d.physical_address = phys_q;
      out_d.out_of_range     = oor_q;
      out_d.page_fault       = status.fault;
      out_d.evicted_page     = status.evicted;
      out_valid_d            = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_q.evicted_page, out_q.physical_address});
  assign m_axis_tuser  = {out_q.page_fault, out_q.out_of_range};

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the FIFO/LRU page translation block.
module testbench;
  import ptfl_pkg::*;

  localparam int PAGES         = DEF_MAX_PAGES;
  localparam int PAGE_SIZE     = DEF_PAGE_BYTES;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 2 * DEF_MAX_PAGES + 8;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = CFG_REPLACEMENT_MODE;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  // Shadow copy of the page table and the registers.
  bit                 page_resident[PAGES];
  logic [AGE_W-1:0]   page_age[PAGES];
  logic               lru_mode;
  logic [PCOUNT_W-1:0] owned_pages;

  ptfl_result_t       pending_translations[$];
  int unsigned        recent_pages[$];
  int                 idle_pct   = 0;
  int                 stall_pct  = 0;
  int                 hold_off   = 0;
  int                 mismatches = 0;
  int                 cycle_count = 0;

  page_translate_fifo_lru dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void clear_page_table();
    for (int i = 0; i < PAGES; i++) begin
      page_resident[i] = (i < RESET_RESIDENT);
      page_age[i]      = (i < RESET_RESIDENT) ? AGE_W'(i) : '0;
    end
    lru_mode    = MODE_FIFO;
    owned_pages = PCOUNT_W'(DEF_PAGE_COUNT);
  endfunction

  function automatic int unsigned active_limit();
    return (owned_pages > PAGES) ? PAGES : owned_pages;
  endfunction

  // Updates the shadow table for one accepted address and returns the translation.
  function automatic ptfl_result_t translate_address(input logic [VA_W-1:0] va);
    ptfl_result_t     res;
    int unsigned      page;
    int unsigned      offs;
    int unsigned      limit;
    int unsigned      victim;
    logic [AGE_W-1:0] oldest;
    res   = '0;
    page  = va / PAGE_SIZE;
    offs  = va % PAGE_SIZE;
    limit = active_limit();
    if (page >= limit) begin
      res.out_of_range = 1'b1;
      return res;
    end
    for (int i = 0; i < limit; i++) begin
      if (page_resident[i] && page_age[i] != AGE_MAX) page_age[i]++;
    end
    if (page_resident[page]) begin
      if (lru_mode == MODE_LRU) page_age[page] = '0;
    end else begin
      // With no resident page of nonzero age in range, page 0 is taken by default.
      oldest = '0;
      victim = 0;
      for (int i = 0; i < limit; i++) begin
        if (page_resident[i] && page_age[i] > oldest) begin
          oldest = page_age[i];
          victim = i;
        end
      end
      page_resident[victim] = 1'b0;
      page_age[victim]      = '0;
      page_resident[page]   = 1'b1;
      res.page_fault        = 1'b1;
      res.evicted_page      = EVICT_W'(victim);
    end
    res.physical_address = VA_W'(page * FRAME_STRIDE * PAGE_SIZE + offs);
    return res;
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_monitor
    ptfl_result_t seen;
    ptfl_result_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      seen.physical_address = m_axis_tdata[VA_W-1:0];
      seen.evicted_page     = m_axis_tdata[VA_W +: EVICT_W];
      seen.out_of_range     = m_axis_tuser[0];
      seen.page_fault       = m_axis_tuser[1];
      if (pending_translations.size() == 0) begin
        $error("unexpected result transfer: tdata %0h, tuser %0h", m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_translations.pop_front();
        compare_field("physical_address", want.physical_address, seen.physical_address);
        compare_field("out_of_range", want.out_of_range, seen.out_of_range);
        compare_field("page_fault", want.page_fault, seen.page_fault);
        compare_field("evicted_page", want.evicted_page, seen.evicted_page);
      end
    end
    // A requested hold-off takes priority over the random stalls.
    if (hold_off > 0) begin
      hold_off = hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_address(input logic [VA_W-1:0] va);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(va);
    do @(posedge clk_i); while (!s_axis_tready);
    pending_translations.push_back(translate_address(va));
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_translations.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic mode, input logic [PCOUNT_W-1:0] count);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_REPLACEMENT_MODE;
    cfg_data_i <= CFG_DATA_W'(mode);
    @(posedge clk_i);
    lru_mode = mode;
    cfg_idx_i  <= CFG_PAGE_COUNT;
    cfg_data_i <= CFG_DATA_W'(count);
    @(posedge clk_i);
    owned_pages = count;
    cfg_we_i <= 1'b0;
  endtask

  // Reuses recently touched pages about half the time so that hits are common; some noise
  // covers the whole address space.
  function automatic logic [VA_W-1:0] pick_address(input int unsigned limit);
    int unsigned roll;
    int unsigned page;
    logic [9:0]  offs;
    roll = $urandom_range(0, 99);
    offs = 10'($urandom());
    if (limit == 0 || roll < 12) return VA_W'($urandom());
    if (roll < 60 && recent_pages.size() > 0)
      page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
    else
      page = $urandom_range(0, limit - 1);
    recent_pages.push_front(page);
    if (recent_pages.size() > 4) void'(recent_pages.pop_back());
    return {10'(page), offs};
  endfunction

  task automatic test_reset_contents();
    send_address(20'h00000);
    send_address(20'h007FF);
    send_address(20'h00BFF);
    send_address(20'h0FFFF);
    send_address(20'hFFFFF);
    send_address(20'h10000);
    send_address(20'h00400);
    wait_for_results();
  endtask

  task automatic test_lru_refresh();
    configure(MODE_LRU, 7'd64);
    send_address(20'h01403);
    send_address(20'h01BFE);
    send_address(20'h01C00);
    send_address(20'h0155A);
    send_address(20'h023FF);
    send_address(20'h01801);
    wait_for_results();
  endtask

  task automatic test_victim_corners();
    int unsigned page;
    int unsigned loaded;
    configure(MODE_FIFO, 7'd64);
    // Three fresh loads push every earlier page, page 0 included, out of the table.
    page   = 20;
    loaded = 0;
    while (loaded < 3) begin
      if (!page_resident[page]) begin
        send_address({10'(page), 10'($urandom())});
        loaded++;
      end
      page++;
    end
    wait_for_results();
    configure(MODE_FIFO, 7'd2);
    send_address(20'h00155);
    send_address(20'h0042A);
    send_address(20'h00800);
    wait_for_results();
    configure(MODE_FIFO, 7'd0);
    send_address(20'h00000);
    wait_for_results();
    configure(MODE_LRU, 7'd127);
    send_address(20'h0FC00);
    send_address(20'h10000);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input logic mode, input logic [PCOUNT_W-1:0] count,
                                     input int send_idle, input int recv_stall,
                                     input int items);
    configure(mode, count);
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    recent_pages.delete();
    repeat (items) send_address(pick_address(active_limit()));
    wait_for_results();
  endtask

  task automatic test_output_backpressure();
    configure(MODE_LRU, 7'd64);
    idle_pct  = 0;
    stall_pct = 0;
    recent_pages.delete();
    hold_off  = 500;
    repeat (12) send_address(pick_address(active_limit()));
    wait_for_results();
  endtask

  initial begin
    clear_page_table();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_contents();
    test_lru_refresh();
    test_victim_corners();
    test_random_traffic(MODE_FIFO, 7'd64, 0, 0, 130);
    test_random_traffic(MODE_LRU, 7'd64, 46, 0, 120);
    test_random_traffic(MODE_LRU, 7'd3, 0, 46, 110);
    test_random_traffic(MODE_FIFO, 7'd17, 24, 24, 120);
    test_random_traffic(MODE_LRU, 7'd100, 0, 0, 100);
    test_random_traffic(MODE_FIFO, 7'd5, 24, 24, 100);
    test_output_backpressure();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
